// ===== rtl/slcd_pkg.sv =====
// shared types, constants and codes for the sync/length/checksum deframer
// no dependencies; imported by every module under rtl but slcd_ram

package slcd_pkg;

  // sync pattern
  localparam logic [7:0] SYNC_A = 8'hAA;
  localparam logic [7:0] SYNC_B = 8'h55;

  // frame geometry
  localparam int          STORE_DEPTH   = 64;
  localparam int          POS_W         = 6;
  localparam logic [7:0]  MIN_LENGTH    = 8'd5;
  localparam logic [POS_W-1:0] FIRST_BYTE_POS = 6'd3;

  // defaults for top level parameters
  localparam int MAX_FRAME_DEF = 64;
  localparam int NUM_SLOTS_DEF = 2;

  // stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  // front-end hunt positions
  localparam logic [POS_W-1:0] POS_HUNT   = 6'd0;
  localparam logic [POS_W-1:0] POS_SYNC_B = 6'd1;
  localparam logic [POS_W-1:0] POS_LENGTH = 6'd2;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SHOW
  } back_state_t;

  // good-frame request from front to queue
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] last_idx;
  } push_req_t;

endpackage

// ===== rtl/slcd_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies

module slcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/slcd_front.sv =====
// front end: sync hunt, length check, body store and checksum
// depends on slcd_pkg; writes frame bytes into the slot named by the queue

module slcd_front #(
  parameter int MAX_FRAME = slcd_pkg::MAX_FRAME_DEF,
  parameter int SLOT_W    = 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic [7:0]                             in_byte,
  output logic                                   in_ready,
  input  logic                                   queue_full,
  input  logic [SLOT_W-1:0]                      wr_slot,
  output logic                                   wr_en,
  output logic [SLOT_W+slcd_pkg::POS_W-1:0]      wr_addr,
  output logic [7:0]                             wr_data,
  output slcd_pkg::push_req_t                    push
);
  import slcd_pkg::*;

  localparam int         LIMIT_INT = (MAX_FRAME < STORE_DEPTH) ? MAX_FRAME : STORE_DEPTH;
  localparam logic [7:0] LEN_LIMIT = 8'(LIMIT_INT);

  logic [POS_W-1:0] position, position_next;
  logic [7:0]       frame_length, frame_length_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       last_idx;
  logic             accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign last_idx = frame_length - 8'd1;
  assign wr_addr  = {wr_slot, position};
  assign wr_data  = in_byte;

  always_comb begin
    position_next     = position;
    frame_length_next = frame_length;
    running_sum_next  = running_sum;
    wr_en             = 1'b0;
    push.valid        = 1'b0;
    push.last_idx     = last_idx[POS_W-1:0];
    if (accept) begin
      if (position == POS_HUNT) begin
        if (in_byte == SYNC_A) begin
          position_next = POS_SYNC_B;
        end
      end else if (position == POS_SYNC_B) begin
        // mismatch drops back to hunting without rechecking this byte
        position_next = (in_byte == SYNC_B) ? POS_LENGTH : POS_HUNT;
      end else if (position == POS_LENGTH) begin
        if (in_byte < MIN_LENGTH || in_byte > LEN_LIMIT) begin
          position_next = POS_HUNT;
        end else begin
          frame_length_next = in_byte;
          running_sum_next  = 8'(SYNC_A + SYNC_B + in_byte);
          position_next     = FIRST_BYTE_POS;
        end
      end else if ({2'b00, position} < last_idx) begin
        wr_en            = 1'b1;
        position_next    = position + 6'd1;
        running_sum_next = running_sum + in_byte;
      end else begin
        // checksum byte
        position_next = POS_HUNT;
        push.valid    = (in_byte == running_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= POS_HUNT;
      frame_length <= '0;
      running_sum  <= '0;
    end else begin
      position     <= position_next;
      frame_length <= frame_length_next;
      running_sum  <= running_sum_next;
    end
  end

endmodule

// ===== rtl/slcd_cmd_queue.sv =====
// queue of good frames between front and back; each entry owns one store slot
// depends on slcd_pkg

module slcd_cmd_queue #(
  parameter int NUM_SLOTS = slcd_pkg::NUM_SLOTS_DEF,
  parameter int SLOT_W    = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  slcd_pkg::push_req_t           push,
  input  logic                          pop,
  output logic                          full,
  output logic [SLOT_W-1:0]             wr_slot,
  output logic                          head_valid,
  output logic [SLOT_W-1:0]             head_slot,
  output logic [slcd_pkg::POS_W-1:0]    head_last_idx
);
  import slcd_pkg::*;

  logic [POS_W-1:0] last_idx_q [NUM_SLOTS];
  logic [SLOT_W-1:0] wr_ptr, rd_ptr;
  logic [SLOT_W:0]   count;
  logic              do_push, do_pop;

  assign full          = (count == (SLOT_W+1)'(NUM_SLOTS));
  assign head_valid    = (count != '0);
  assign wr_slot       = wr_ptr;
  assign head_slot     = rd_ptr;
  assign head_last_idx = last_idx_q[rd_ptr];
  assign do_push       = push.valid && !full;
  assign do_pop        = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      last_idx_q[wr_ptr] <= push.last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == SLOT_W'(NUM_SLOTS - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == SLOT_W'(NUM_SLOTS - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (SLOT_W+1)'(do_push) - (SLOT_W+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/slcd_back.sv =====
// back end: plays out a queued frame from its store slot, one byte per request
// depends on slcd_pkg; reads the frame store through its registered port

module slcd_back #(
  parameter int SLOT_W = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                head_valid,
  input  logic [SLOT_W-1:0]                   head_slot,
  input  logic [slcd_pkg::POS_W-1:0]          head_last_idx,
  output logic                                pop,
  output logic                                rd_en,
  output logic [SLOT_W+slcd_pkg::POS_W-1:0]   rd_addr,
  input  logic [7:0]                          rd_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_byte,
  output logic [slcd_pkg::POS_W-1:0]          out_pos,
  output logic                                out_last
);
  import slcd_pkg::*;

  back_state_t      state, state_next;
  logic [POS_W-1:0] idx, idx_next;
  logic             is_last;

  assign is_last  = (idx == head_last_idx - 6'd1);
  assign rd_addr  = {head_slot, idx};
  assign out_byte = rd_data;
  assign out_pos  = idx - FIRST_BYTE_POS;
  assign out_last = is_last;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      BK_IDLE: begin
        if (head_valid) begin
          state_next = BK_READ;
          idx_next   = FIRST_BYTE_POS;
        end
      end
      BK_READ: state_next = BK_SHOW;
      BK_SHOW: begin
        if (out_ready) begin
          if (is_last) begin
            state_next = BK_IDLE;
          end else begin
            state_next = BK_READ;
            idx_next   = idx + 6'd1;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    rd_en     = 1'b0;
    out_valid = 1'b0;
    pop       = 1'b0;
    case (state)
      BK_READ: rd_en = 1'b1;
      BK_SHOW: begin
        out_valid = 1'b1;
        pop       = out_ready && is_last;
      end
      default: begin
        rd_en     = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      idx   <= FIRST_BYTE_POS;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// ===== rtl/sync_length_checksum_deframer_core.sv =====
// top level of the two-byte-sync, length, sum8 checksum deframer
// depends on slcd_pkg, slcd_front, slcd_cmd_queue, slcd_back, slcd_ram
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+------------------------------------------
//  rx      | in  | s_tvalid/s_tready | s_tdata[7:0] rx_byte
//  frame   | out | m_tvalid/m_tready | m_tdata[7:0] frame_byte, [13:8] byte_pos,
//          |     |                  | [15:14] zero; m_tlast last
//
// the front takes one rx byte per cycle whenever a store slot is free; it
// stalls (s_tready low) only while every slot holds a good frame not yet played
// each played byte passes through a ram read state, then a state that presents it;
// the registered ram read data is the output register and holds under stall
// a frame of length L gives L-4 output requests once its checksum byte lands
// synchronous active high reset clears the hunt state, queue and playout fsm;
// the frame store itself needs no reset

module sync_length_checksum_deframer_core #(
  parameter int MAX_FRAME = slcd_pkg::MAX_FRAME_DEF,  // 5 .. 255, capped at 64
  parameter int NUM_SLOTS = slcd_pkg::NUM_SLOTS_DEF   // frame slots, 2 or more
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [slcd_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] rx_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [slcd_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [7:0] frame_byte, [13:8] byte_pos
  output logic                              m_tlast   // last
);
  import slcd_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int ADDR_W = SLOT_W + POS_W;

  // front to store and queue
  logic              queue_full;
  logic [SLOT_W-1:0] wr_slot;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  push_req_t         push;

  // queue to back
  logic              head_valid;
  logic [SLOT_W-1:0] head_slot;
  logic [POS_W-1:0]  head_last_idx;
  logic              pop;

  // back to store and output
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic [7:0]        out_byte;
  logic [POS_W-1:0]  out_pos;

  slcd_front #(
    .MAX_FRAME (MAX_FRAME),
    .SLOT_W    (SLOT_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata[7:0]),
    .in_ready   (s_tready),
    .queue_full (queue_full),
    .wr_slot    (wr_slot),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .push       (push)
  );

  // one slot per queue entry, so a slot being played is never overwritten
  slcd_cmd_queue #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_queue (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .pop           (pop),
    .full          (queue_full),
    .wr_slot       (wr_slot),
    .head_valid    (head_valid),
    .head_slot     (head_slot),
    .head_last_idx (head_last_idx)
  );

  slcd_ram #(
    .WIDTH (8),
    .DEPTH (NUM_SLOTS * STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  slcd_back #(
    .SLOT_W (SLOT_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_slot     (head_slot),
    .head_last_idx (head_last_idx),
    .pop           (pop),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_byte      (out_byte),
    .out_pos       (out_pos),
    .out_last      (m_tlast)
  );

  // pack output fields, lowest first, zero fill to whole bytes
  assign m_tdata = {(OUT_TDATA_W - 8 - POS_W)'(0), out_pos, out_byte};

endmodule

// ===== sim/sync_length_checksum_deframer_core_tb.sv =====
`timescale 1ns / 100ps
// testbench for the sync/length/checksum deframer core: random and directed rx bytes
// depends on slcd_pkg and sync_length_checksum_deframer_core under rtl

// one played-out frame byte as it should appear on the output stream
typedef struct packed {
  logic [7:0] data;
  logic [5:0] pos;
  logic       last;
} frame_beat_t;

// tracks the hunt/length/sum state and holds the frame bytes still owed
class deframe_scoreboard;
  localparam int LEN_LIMIT = (slcd_pkg::MAX_FRAME_DEF < slcd_pkg::STORE_DEPTH) ?
                             slcd_pkg::MAX_FRAME_DEF : slcd_pkg::STORE_DEPTH;

  logic [5:0]  hunt_pos;
  logic [7:0]  frame_len;
  logic [7:0]  sum8;
  logic [7:0]  store [slcd_pkg::STORE_DEPTH];
  frame_beat_t owed [$];
  int          errors;

  function new();
    hunt_pos  = slcd_pkg::POS_HUNT;
    frame_len = 8'd0;
    sum8      = 8'd0;
    errors    = 0;
  endfunction

  function int pending();
    return owed.size();
  endfunction

  task report(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  // advance the deframer state by one accepted rx request
  function void note_request(input logic [7:0] b);
    logic [7:0]  last_idx;
    frame_beat_t beat;
    int          i;
    if (hunt_pos == slcd_pkg::POS_HUNT) begin
      if (b == slcd_pkg::SYNC_A) hunt_pos = slcd_pkg::POS_SYNC_B;
    end else if (hunt_pos == slcd_pkg::POS_SYNC_B) begin
      // a wrong second sync byte is not retried as a first one
      hunt_pos = (b == slcd_pkg::SYNC_B) ? slcd_pkg::POS_LENGTH : slcd_pkg::POS_HUNT;
    end else if (hunt_pos == slcd_pkg::POS_LENGTH) begin
      if (b < slcd_pkg::MIN_LENGTH || int'(b) > LEN_LIMIT) begin
        hunt_pos = slcd_pkg::POS_HUNT;
      end else begin
        frame_len = b;
        sum8      = slcd_pkg::SYNC_A + slcd_pkg::SYNC_B + b;
        hunt_pos  = slcd_pkg::FIRST_BYTE_POS;
      end
    end else begin
      last_idx = frame_len - 8'd1;
      if ({2'b00, hunt_pos} < last_idx) begin
        store[hunt_pos] = b;
        hunt_pos        = hunt_pos + 6'd1;
        sum8            = sum8 + b;
      end else begin
        hunt_pos = slcd_pkg::POS_HUNT;
        if (b == sum8) begin
          for (i = 3; i < int'(last_idx); i++) begin
            beat.data = store[i];
            beat.pos  = 6'(i - 3);
            beat.last = (i + 1 == int'(last_idx));
            owed.push_back(beat);
          end
        end
      end
    end
  endfunction

  task check_result(input logic [15:0] tdata, input logic tlast);
    frame_beat_t want;
    if (owed.size() == 0) begin
      report($sformatf("unexpected frame byte %02h pos %0d last %0b",
                       tdata[7:0], tdata[13:8], tlast));
    end else begin
      want = owed.pop_front();
      if (tdata[7:0] !== want.data || tdata[13:8] !== want.pos || tlast !== want.last)
        report($sformatf("got byte %02h pos %0d last %0b, want byte %02h pos %0d last %0b",
                         tdata[7:0], tdata[13:8], tlast, want.data, want.pos, want.last));
    end
  endtask
endclass

module sync_length_checksum_deframer_core_tb;

  localparam int RANDOM_ITEMS = 290;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  deframe_scoreboard sb;
  int  cycles = 0;
  int  random_sent = 0;
  bit  hold_req = 1'b0;   // sender asks the receiver for one long hold-off
  bit  rx_hold = 1'b0;    // receiver is in that hold-off

  sync_length_checksum_deframer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // output side: every accepted frame byte is checked against the oldest owed one
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  // offer one rx byte, idle first if a gap is asked, return once accepted
  task automatic send_byte(input logic [7:0] b, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_request(b);
  endtask

  task automatic send_gapped(input logic [7:0] b, input bit burst);
    send_byte(b, (burst || rx_hold) ? 0 : pick_gap());
  endtask

  // body bytes lean toward the sync values now and then
  function automatic logic [7:0] pick_body();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return slcd_pkg::SYNC_A;
    if (r == 1) return slcd_pkg::SYNC_B;
    return 8'($urandom_range(0, 255));
  endfunction

  // whole frame: sync, length and payload, then a good or corrupted checksum
  task automatic send_frame(input logic [7:0] flen, input bit good_sum, input bit burst);
    logic [7:0] acc;
    logic [7:0] v;
    int         k;
    acc = slcd_pkg::SYNC_A + slcd_pkg::SYNC_B + flen;
    send_gapped(slcd_pkg::SYNC_A, burst);
    send_gapped(slcd_pkg::SYNC_B, burst);
    send_gapped(flen, burst);
    for (k = 3; k < int'(flen) - 1; k++) begin
      v   = pick_body();
      acc = acc + v;
      send_gapped(v, burst);
    end
    send_gapped(good_sum ? acc : acc ^ 8'($urandom_range(1, 255)), burst);
    random_sent += int'(flen);
  endtask

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 8'($urandom_range(5, 12));
    if (r < 95) return 8'($urandom_range(13, 30));
    return 8'($urandom_range(31, 64));
  endfunction

  // output-side readiness, with one long hold-off on request
  initial begin
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        rx_hold  = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            m_tready <= 1'b1;
            repeat ($urandom_range(60, 150)) @(posedge clk);
          end
          1: begin
            m_tready <= 1'b0;
            repeat ($urandom_range(15, 50)) @(posedge clk);
          end
          2, 3, 4: begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
          end
          default: begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
          end
        endcase
      end
    end
  end

  // input side
  initial begin
    int  r;
    int  k;
    bit  held;
    bit  drained;
    held    = 1'b0;
    drained = 1'b0;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // noise while hunting, including a lone second sync byte
    send_byte(8'h00, 0);
    send_byte(8'hFF, 1);
    send_byte(slcd_pkg::SYNC_B, 0);
    // repeated first sync: the second one breaks the sync and is not retried
    send_byte(slcd_pkg::SYNC_A, 0);
    send_byte(slcd_pkg::SYNC_A, 0);
    send_byte(slcd_pkg::SYNC_B, 0);
    // length just below the minimum, just above the maximum, and all ones
    send_byte(slcd_pkg::SYNC_A, 0);
    send_byte(slcd_pkg::SYNC_B, 0);
    send_byte(8'd4, 0);
    send_byte(slcd_pkg::SYNC_A, 2);
    send_byte(slcd_pkg::SYNC_B, 0);
    send_byte(8'd65, 0);
    send_byte(slcd_pkg::SYNC_A, 0);
    send_byte(slcd_pkg::SYNC_B, 0);
    send_byte(8'hFF, 0);
    // shortest frame, good then with a bad checksum
    send_frame(8'd5, 1'b1, 1'b1);
    send_frame(8'd5, 1'b0, 1'b0);
    // longest frame
    send_frame(8'd64, 1'b1, 1'b0);
    random_sent = 0;

    while (random_sent < RANDOM_ITEMS) begin
      if (!held && random_sent >= 100) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!drained && random_sent >= 240) begin
        // sender pauses until every owed frame byte is out
        drained = 1'b1;
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      r = $urandom_range(0, 99);
      if (rx_hold || hold_req || r < 78) begin
        send_frame(pick_length(), 1'b1, $urandom_range(0, 2) == 0);
      end else if (r < 86) begin
        send_frame(pick_length(), 1'b0, 1'b0);
      end else if (r < 90) begin
        send_gapped(slcd_pkg::SYNC_A, 1'b0);
        send_gapped(8'($urandom_range(0, 255)), 1'b0);
        random_sent += 2;
      end else if (r < 94) begin
        send_gapped(slcd_pkg::SYNC_A, 1'b0);
        send_gapped(slcd_pkg::SYNC_B, 1'b0);
        send_gapped($urandom_range(0, 1) ? 8'($urandom_range(0, 4))
                                         : 8'($urandom_range(65, 255)), 1'b0);
        random_sent += 3;
      end else begin
        for (k = 0; k < 3; k++) send_gapped(8'($urandom_range(0, 255)), 1'b0);
        random_sent += 3;
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
